// ===== hw/rtl/lcgpr_pkg.sv =====
// Package for the LCG parameter recovery block.
// Holds widths, payload, state, status and command types shared by all files.
`default_nettype none
package lcgpr_pkg;
  localparam int unsigned W = 16;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NO_INV   = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture item
    OP_RED_X0,    // r0 = x0 mod m
    OP_RED_X1,
    OP_RED_X2,
    OP_DIFF,      // d, n
    OP_EUC_INIT,
    OP_EUC_DIV,   // one quotient via divider
    OP_EUC_STEP,
    OP_EUC_FIN,
    OP_MUL,       // prod = mul_x*mul_y + add_v (registered)
    OP_MOD,       // k = prod mod m via divider
    OP_SAVE
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED0, S_RED1, S_RED2, S_DIFF, S_EINIT, S_EDIV, S_EDIVW, S_ESTEP,
    S_EFIN, S_A_MUL, S_A_MOD, S_A_SAVE, S_C_MUL, S_C_MOD, S_C_SAVE,
    S_K_MUL, S_K_MOD, S_K_SAVE, S_DONE, S_RED0W, S_RED1W, S_RED2W
  } state_t;

  // Which value a multiply/reduce step works on
  typedef enum logic [2:0] {
    SEL_A, SEL_C, SEL_K0, SEL_K1, SEL_K2, SEL_K3
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic r1_zero;   // Euclid remainder is zero
    logic d_zero;
    logic gcd_one;
    logic check_ok;
  } sts_t;

  typedef struct packed {
    logic [W-1:0] value_0;
    logic [W-1:0] value_1;
    logic [W-1:0] value_2;
    logic [W-1:0] value_3;
    logic [W-1:0] candidate_modulus;
  } item_t;

  typedef struct packed {
    status_t      status;
    logic [W-1:0] multiplier;
    logic [W-1:0] increment;
    logic [W-1:0] predicted_value;
  } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lcgpr_if.sv =====
// Valid/ready channel interfaces for item and result transfers.
// Payload types come from lcgpr_pkg.
`default_nettype none
interface lcgpr_in_if;
  logic              valid;
  logic              ready;
  lcgpr_pkg::item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcgpr_out_if;
  logic               valid;
  logic               ready;
  lcgpr_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lcgpr_div.sv =====
// Restoring divider: 32-bit dividend by 16-bit divisor, one bit per cycle.
// Uses lcgpr_pkg for widths.
`default_nettype none
module lcgpr_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [2*lcgpr_pkg::W-1:0] dividend,
  input  wire logic [lcgpr_pkg::W-1:0]   divisor,
  output logic                           done,
  output logic [2*lcgpr_pkg::W-1:0]      quot,
  output logic [lcgpr_pkg::W-1:0]        rem
);
  import lcgpr_pkg::*;
  logic [5:0]     cnt;
  logic           busy;
  logic [2*W-1:0] q;
  logic [W:0]     r;
  logic [W-1:0]   dv;
  logic [W:0]     sh;

  assign sh = {r[W-1:0], q[2*W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(2*W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q  <= dividend;
      r  <= '0;
      dv <= divisor;
    end else if (busy) begin
      if (sh >= {1'b0, dv}) begin
        r <= sh - {1'b0, dv};
        q <= {q[2*W-2:0], 1'b1};
      end else begin
        r <= sh;
        q <= {q[2*W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
  assign rem  = r[W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/lcgpr_datapath.sv =====
// Datapath: residues, extended Euclid, products and checks.
// Uses lcgpr_pkg and the lcgpr_div shared divider.
`default_nettype none
module lcgpr_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lcgpr_pkg::cmd_t         cmd,
  input  wire logic [4*lcgpr_pkg::W-1:0] item_x,
  input  wire logic [lcgpr_pkg::W-1:0] item_m,
  output lcgpr_pkg::sts_t              sts,
  output logic [lcgpr_pkg::W-1:0]      a_out,
  output logic [lcgpr_pkg::W-1:0]      c_out,
  output logic [lcgpr_pkg::W-1:0]      p_out
);
  import lcgpr_pkg::*;
  logic [W-1:0] x0, x1, x2, x3, m;
  logic [W-1:0] r0, r1, r2, d, n;
  // Euclid remainders and signed Bezout coefficients
  logic [W-1:0]   er0, er1;
  logic signed [W+1:0] t0, t1;
  logic [W-1:0]   inv, a, c, k;
  logic [2*W:0]   prod;
  logic [2*W-1:0] mul_p;
  logic           ok;
  logic [2*W-1:0] div_a;
  logic [W-1:0]   div_b;
  logic           done;
  logic [2*W-1:0] quot;
  logic [W-1:0]   rem;
  logic [W-1:0]   mul_x, mul_y, add_v, cmp_v;
  logic [W:0]     sum;
  logic signed [W+1:0] tm;
  logic signed [2*W+3:0] qt;

  always_comb begin
    div_a = {{W{1'b0}}, x0};
    div_b = m;
    unique case (cmd.op)
      OP_RED_X0: div_a = {{W{1'b0}}, x0};
      OP_RED_X1: div_a = {{W{1'b0}}, x1};
      OP_RED_X2: div_a = {{W{1'b0}}, x2};
      OP_EUC_DIV: begin
        div_a = {{W{1'b0}}, er0};
        div_b = er1;
      end
      OP_MOD: div_a = prod[2*W-1:0];
      default: ;
    endcase
  end

  lcgpr_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .done(done), .quot(quot), .rem(rem)
  );

  always_comb begin
    mul_x = n;
    mul_y = inv;
    add_v = '0;
    unique case (cmd.sel)
      SEL_A: begin mul_x = n; mul_y = inv; end
      SEL_C: begin mul_x = a; mul_y = r0; end
      SEL_K0: begin mul_x = a; mul_y = x0; add_v = c; end
      SEL_K1: begin mul_x = a; mul_y = x1; add_v = c; end
      SEL_K2: begin mul_x = a; mul_y = x2; add_v = c; end
      SEL_K3: begin mul_x = a; mul_y = x3; add_v = c; end
      default: ;
    endcase
  end

  always_comb begin
    cmp_v = x1;
    case (cmd.sel)
      SEL_K1: cmp_v = x2;
      SEL_K2: cmp_v = x3;
      default: cmp_v = x1;
    endcase
  end

  // full 32-bit product of two 16-bit operands
  assign mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  // c = (r1 - a*r0 mod m) mod m
  assign sum = (r1 >= rem) ? {1'b0, r1 - rem} : {1'b0, r1} + {1'b0, m} - {1'b0, rem};
  assign qt  = $signed({2'b0, quot}) * t1;
  assign tm  = t0 + $signed({2'b0, m});

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        {x3, x2, x1, x0} <= item_x;
        m <= item_m;
        ok <= 1'b1;
      end
      OP_RED_X0: if (done) r0 <= rem;
      OP_RED_X1: if (done) r1 <= rem;
      OP_RED_X2: if (done) r2 <= rem;
      OP_DIFF: begin
        d <= (r1 >= r0) ? r1 - r0 : W'({1'b0, r1} + {1'b0, m} - {1'b0, r0});
        n <= (r2 >= r1) ? r2 - r1 : W'({1'b0, r2} + {1'b0, m} - {1'b0, r1});
      end
      OP_EUC_INIT: begin
        er0 <= m;
        er1 <= d;
        t0  <= '0;
        t1  <= (W+2)'(1);
      end
      OP_EUC_STEP: begin
        er0 <= er1;
        er1 <= rem;
        t0  <= t1;
        t1  <= t0 - (W+2)'(qt);
      end
      OP_EUC_FIN: inv <= (t0 < 0) ? tm[W-1:0] : t0[W-1:0];
      OP_MUL: prod <= {1'b0, mul_p} + {{(W+1){1'b0}}, add_v};
      OP_MOD: if (done) k <= rem;
      OP_SAVE: begin
        unique case (cmd.sel)
          SEL_A: a <= k;
          SEL_C: c <= W'(sum);
          SEL_K3: ;
          default: if (k != cmp_v) ok <= 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  assign sts = '{div_done: done,
                 r1_zero:  (er1 == '0),
                 d_zero:   (d == '0),
                 gcd_one:  (er0 == W'(1)),
                 check_ok: ok};
  assign a_out = a;
  assign c_out = c;
  assign p_out = k;
endmodule
`default_nettype wire

// ===== hw/rtl/lcgpr_ctrl.sv =====
// Controller state machine sequencing the datapath for one item.
// Uses lcgpr_pkg command and status types.
`default_nettype none
module lcgpr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic [lcgpr_pkg::W-1:0] m,
  input  wire lcgpr_pkg::sts_t   sts,
  output lcgpr_pkg::cmd_t        cmd,
  output lcgpr_pkg::status_t     status,
  output logic                   take
);
  import lcgpr_pkg::*;
  state_t state, state_next;
  sel_t   ksel, ksel_next;
  status_t st, st_next;
  logic   busy;
  logic   finish;

  // S_DONE also serves each transition check; the item ends only on the last visit
  assign finish = (state == S_DONE) && !(st == ST_MATCH && ksel != SEL_K3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ksel      <= SEL_K0;
      st        <= ST_MATCH;
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      state <= state_next;
      ksel  <= ksel_next;
      st    <= st_next;
      if (finish) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) busy <= 1'b1;
    end
  end

  // One item in flight; accept again once its result has been taken
  assign in_ready = (state == S_IDLE) && !busy && !out_valid;
  assign status   = st;
  assign take     = finish && (st == ST_MATCH);

  always_comb begin
    state_next = state;
    ksel_next  = ksel;
    st_next    = st;
    cmd        = '{op: OP_NONE, sel: ksel, div_start: 1'b0};
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.op = OP_LOAD;
        if (m < 16'd2) begin
          st_next    = ST_ZERO;
          state_next = S_DONE;
        end else begin
          st_next    = ST_MATCH;
          state_next = S_RED0;
        end
      end
      S_RED0: begin cmd.op = OP_RED_X0; cmd.div_start = 1'b1; state_next = S_RED0W; end
      S_RED0W: begin cmd.op = OP_RED_X0; if (sts.div_done) state_next = S_RED1; end
      S_RED1: begin cmd.op = OP_RED_X1; cmd.div_start = 1'b1; state_next = S_RED1W; end
      S_RED1W: begin cmd.op = OP_RED_X1; if (sts.div_done) state_next = S_RED2; end
      S_RED2: begin cmd.op = OP_RED_X2; cmd.div_start = 1'b1; state_next = S_RED2W; end
      S_RED2W: begin cmd.op = OP_RED_X2; if (sts.div_done) state_next = S_DIFF; end
      S_DIFF: begin cmd.op = OP_DIFF; state_next = S_EINIT; end
      S_EINIT: begin
        if (sts.d_zero) begin
          st_next    = ST_ZERO;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_EUC_INIT;
          state_next = S_EDIV;
        end
      end
      S_EDIV: begin
        if (sts.r1_zero) begin
          state_next = S_EFIN;
        end else begin
          cmd.op = OP_EUC_DIV; cmd.div_start = 1'b1; state_next = S_EDIVW;
        end
      end
      S_EDIVW: begin cmd.op = OP_EUC_DIV; if (sts.div_done) state_next = S_ESTEP; end
      S_ESTEP: begin cmd.op = OP_EUC_STEP; state_next = S_EDIV; end
      S_EFIN: begin
        if (!sts.gcd_one) begin
          st_next    = ST_NO_INV;
          state_next = S_DONE;
        end else begin
          cmd.op = OP_EUC_FIN; state_next = S_A_MUL;
        end
      end
      S_A_MUL: begin cmd = '{op: OP_MUL, sel: SEL_A, div_start: 1'b0}; state_next = S_A_MOD; end
      S_A_MOD: begin
        cmd = '{op: OP_MOD, sel: SEL_A, div_start: 1'b1}; state_next = S_A_SAVE;
      end
      S_A_SAVE: begin
        cmd = '{op: OP_MOD, sel: SEL_A, div_start: 1'b0};
        if (sts.div_done) begin
          state_next = S_C_MUL;
        end
      end
      S_C_MUL: begin
        // commit a, then form a*r0
        cmd = '{op: OP_SAVE, sel: SEL_A, div_start: 1'b0}; state_next = S_C_MOD;
      end
      S_C_MOD: begin
        cmd = '{op: OP_MUL, sel: SEL_C, div_start: 1'b0}; state_next = S_C_SAVE;
      end
      S_C_SAVE: begin
        // start on entry; ksel marks the reduction as running
        cmd = '{op: OP_MOD, sel: SEL_C, div_start: (ksel != SEL_C)};
        ksel_next = SEL_C;
        if (ksel == SEL_C && sts.div_done) begin
          cmd.op     = OP_SAVE;
          ksel_next  = SEL_K0;
          state_next = S_K_MUL;
        end
      end
      S_K_MUL: begin cmd = '{op: OP_MUL, sel: ksel, div_start: 1'b0}; state_next = S_K_MOD; end
      S_K_MOD: begin cmd = '{op: OP_MOD, sel: ksel, div_start: 1'b1}; state_next = S_K_SAVE; end
      S_K_SAVE: begin
        cmd = '{op: OP_MOD, sel: ksel, div_start: 1'b0};
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
        if (st == ST_MATCH && ksel != SEL_K3) begin
          // check one transition, then advance
          cmd = '{op: OP_SAVE, sel: ksel, div_start: 1'b0};
          unique case (ksel)
            SEL_K0: ksel_next = SEL_K1;
            SEL_K1: ksel_next = SEL_K2;
            default: ksel_next = SEL_K3;
          endcase
          state_next = S_K_MUL;
        end else begin
          ksel_next = SEL_K0;
          if (st == ST_MATCH && !sts.check_ok) st_next = ST_MISMATCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start) |=> !sts.div_done)
    else $error("divider done right after start");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("result dropped or changed while stalled");
endmodule
`default_nettype wire

// ===== hw/rtl/lcg_parameter_recovery.sv =====
// Top level of the LCG parameter recovery block.
// Uses lcgpr_pkg, lcgpr_if, lcgpr_ctrl and lcgpr_datapath.
//
// Tests one candidate modulus against four samples and returns status, multiplier,
// increment and predicted next sample. One item is in flight at a time and every
// residue, Euclid quotient and product reduction shares one bit-serial divider. A
// modulus below two or a zero difference ends the item early with ST_ZERO status.
// A full run takes three residues, one divider use per Euclid quotient (at most 23
// for a 16-bit modulus) and six product reductions. A new item is taken once the
// result transfers.
`default_nettype none
module lcg_parameter_recovery (
  input wire logic     clk,
  input wire logic     rst,
  lcgpr_in_if.sink     in_ch,
  lcgpr_out_if.source  out_ch
);
  import lcgpr_pkg::*;
  cmd_t    cmd;
  sts_t    sts;
  status_t st;
  logic    take;
  logic [W-1:0] a_v, c_v, p_v;
  logic [W-1:0] ra, rc, rp;

  lcgpr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .m(in_ch.data.candidate_modulus), .sts(sts), .cmd(cmd), .status(st), .take(take)
  );

  lcgpr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .item_x({in_ch.data.value_3, in_ch.data.value_2, in_ch.data.value_1,
             in_ch.data.value_0}),
    .item_m(in_ch.data.candidate_modulus), .sts(sts),
    .a_out(a_v), .c_out(c_v), .p_out(p_v)
  );

  // hold the result fields; zero unless match
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      ra <= '0; rc <= '0; rp <= '0;
    end else if (take && sts.check_ok) begin
      ra <= a_v; rc <= c_v; rp <= p_v;
    end
  end

  assign out_ch.data = '{status:          (st == ST_MATCH && !sts.check_ok) ? ST_MISMATCH : st,
                         multiplier:      ra,
                         increment:       rc,
                         predicted_value: rp};
endmodule
`default_nettype wire

// ===== tb/sv/lcg_parameter_recovery_tb.sv =====
// Self-checking testbench for lcg_parameter_recovery.
// Depends on lcgpr_pkg, lcgpr_if and the block itself; it predicts each result in place.
`default_nettype none
module lcg_parameter_recovery_tb;
  import lcgpr_pkg::*;

  typedef item_t   sample_set_t;
  typedef result_t recovery_t;

  localparam int unsigned RANDOM_SETS = 2000;
  localparam int unsigned PHASE_LEN   = 250;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned DRAIN_WAIT  = 2500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lcgpr_in_if  in_ch ();
  lcgpr_out_if out_ch ();

  lcg_parameter_recovery dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  sample_set_t sample_sets[$];
  recovery_t   expected_recoveries[$];
  int unsigned sets_sent    = 0;
  int unsigned mismatches   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          pause_done   = 1'b0;
  bit          stimulus_done = 1'b0;

  function automatic longint step_lcg(longint x, longint a, longint c, longint m);
    return (a * x + c) % m;
  endfunction

  function automatic recovery_t recover_params(sample_set_t s);
    recovery_t res;
    longint x0, x1, x2, x3, m, r0, r1, r2, d, n;
    longint g0, g1, t0, t1, q, tmp, inv, a, c, pred;
    x0 = s.value_0;
    x1 = s.value_1;
    x2 = s.value_2;
    x3 = s.value_3;
    m  = s.candidate_modulus;
    res = '0;
    res.status = ST_ZERO;
    if (m < 2) return res;
    r0 = x0 % m;
    r1 = x1 % m;
    r2 = x2 % m;
    d = (r1 + m - r0) % m;
    n = (r2 + m - r1) % m;
    if (d == 0) return res;
    g0 = m; g1 = d; t0 = 0; t1 = 1;
    while (g1 != 0) begin
      q = g0 / g1;
      tmp = g0 - q * g1; g0 = g1; g1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (g0 != 1) begin
      res.status = ST_NO_INV;
      return res;
    end
    if (t0 < 0) t0 += m;
    inv = t0 % m;
    a = (n * inv) % m;
    c = (r1 + m - (a * r0) % m) % m;
    if (step_lcg(x0, a, c, m) == x1 && step_lcg(x1, a, c, m) == x2 &&
        step_lcg(x2, a, c, m) == x3) begin
      pred = step_lcg(x3, a, c, m);
      res.status          = ST_MATCH;
      res.multiplier      = a[15:0];
      res.increment       = c[15:0];
      res.predicted_value = pred[15:0];
    end else begin
      res.status = ST_MISMATCH;
    end
    return res;
  endfunction

  // Build a true generator run; x0 may be anywhere below m.
  function automatic sample_set_t make_run(int unsigned m, int unsigned a, int unsigned c,
                                           int unsigned x0);
    sample_set_t s;
    s.candidate_modulus = 16'(m);
    s.value_0 = 16'(x0);
    s.value_1 = 16'(step_lcg(x0, a, c, m));
    s.value_2 = 16'(step_lcg(s.value_1, a, c, m));
    s.value_3 = 16'(step_lcg(s.value_2, a, c, m));
    return s;
  endfunction

  function automatic int unsigned pick_modulus();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(2, 300);
    if (pick < 95) return $urandom_range(2, 65535);
    return 65535;
  endfunction

  initial begin
    sample_set_t s;
    int unsigned m, k;
    // Out-of-range moduli, all-zero samples and all-ones samples.
    sample_sets.push_back('{16'd5, 16'd7, 16'd9, 16'd11, 16'd0});
    sample_sets.push_back('{16'd0, 16'd1, 16'd0, 16'd1, 16'd1});
    sample_sets.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 16'd65535});
    sample_sets.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    sample_sets.push_back('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    // Difference shares a factor with m.
    sample_sets.push_back('{16'd1, 16'd3, 16'd5, 16'd7, 16'd10});
    // Samples at or above m.
    sample_sets.push_back('{16'd1, 16'd12, 16'd3, 16'd4, 16'd10});
    sample_sets.push_back('{16'd0, 16'd1, 16'd2, 16'd40000, 16'd100});
    // Negative differences, smallest modulus, largest modulus.
    sample_sets.push_back(make_run(97, 5, 3, 90));
    sample_sets.push_back(make_run(2, 1, 1, 0));
    sample_sets.push_back(make_run(2, 1, 0, 1));
    sample_sets.push_back(make_run(65535, 65534, 65534, 65534));
    sample_sets.push_back(make_run(65535, 12345, 54321, 1));
    sample_sets.push_back(make_run(65521, 48271, 0, 65520));
    sample_sets.push_back(make_run(13, 0, 7, 2));
    sample_sets.push_back(make_run(256, 5, 1, 255));
    for (int i = 0; i < RANDOM_SETS; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        m = pick_modulus();
        s = make_run(m, $urandom_range(0, m - 1), $urandom_range(0, m - 1),
                     $urandom_range(0, m - 1));
      end else if (k < 85) begin
        m = pick_modulus();
        s = make_run(m, $urandom_range(0, m - 1), $urandom_range(0, m - 1),
                     $urandom_range(0, m - 1));
        case ($urandom_range(0, 3))
          0: s.value_1 = 16'($urandom);
          1: s.value_2 = 16'($urandom);
          2: s.value_3 = 16'($urandom);
          default: s.candidate_modulus = 16'($urandom_range(0, 65535));
        endcase
      end else begin
        s.value_0 = 16'($urandom);
        s.value_1 = 16'($urandom);
        s.value_2 = 16'($urandom);
        s.value_3 = 16'($urandom);
        s.candidate_modulus = 16'($urandom);
      end
      sample_sets.push_back(s);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Driver: phases rotate every PHASE_LEN transfers.
  always @(posedge clk) begin
    bit offer;
    int unsigned phase;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_recoveries.push_back(recover_params(in_ch.data));
        sets_sent++;
      end
      if (sets_sent == 1000 && !pause_done && expected_recoveries.size() != 0) begin
        offer = 1'b0;
      end else begin
        if (sets_sent == 1000) pause_done = 1'b1;
        phase = (sets_sent / PHASE_LEN) % 4;
        offer = sample_sets.size() != 0;
        if (phase == 1 && $urandom_range(0, 99) < 49) offer = 1'b0;
        if (phase == 3 && $urandom_range(0, 99) < 30) offer = 1'b0;
      end
      if (offer) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= sample_sets.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the block fills and backs up its input.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (sets_sent == 300 && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
      end
    end
  end

  // Monitor: compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    recovery_t want;
    bit take;
    int unsigned phase;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_recoveries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          want = expected_recoveries.pop_front();
          if (out_ch.data.status !== want.status ||
              out_ch.data.multiplier !== want.multiplier ||
              out_ch.data.increment !== want.increment ||
              out_ch.data.predicted_value !== want.predicted_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, out_ch.data);
          end
        end
      end
      phase = (sets_sent / PHASE_LEN) % 4;
      take = 1'b1;
      if (phase == 2 && $urandom_range(0, 99) < 49) take = 1'b0;
      if (phase == 3 && $urandom_range(0, 99) < 30) take = 1'b0;
      if (hold_left != 0) take = 1'b0;
      out_ch.ready <= take;
    end
  end

  initial begin
    wait (stimulus_done);
    wait (sample_sets.size() == 0 && !in_ch.valid);
    wait (expected_recoveries.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_recoveries.size() == 0) begin
      $display("PASS lcg_parameter_recovery");
    end else begin
      $display("FAIL lcg_parameter_recovery");
    end
    $finish;
  end

  initial begin
    #120000000;
    $display("FAIL lcg_parameter_recovery");
    $finish;
  end
endmodule
`default_nettype wire
